// File: hw/rtl/wdua_pkg.sv
// ----------------------------------------------------------------------------
// wdua_pkg
// Types and constants shared by the wind direction averager modules.
// ----------------------------------------------------------------------------
package wdua_pkg;

  localparam int unsigned MaxSamples  = 128;
  localparam int unsigned DirW        = 8;
  localparam int unsigned CntW        = $clog2(MaxSamples + 1);
  localparam int unsigned SumW        = 24;
  localparam int unsigned LastW       = 18;
  localparam int unsigned DegW        = 9;
  localparam int unsigned DegPerTurn  = 360;
  localparam int unsigned ProdW       = DirW + DegW;
  localparam int unsigned QueueDepth  = 2;
  localparam int unsigned QueuePtrW   = $clog2(QueueDepth);
  localparam int unsigned QueueCntW   = $clog2(QueueDepth + 1);
  localparam int unsigned IterW       = $clog2(SumW);

  localparam logic [DirW-1:0] HalfTurn = DirW'(128);

  localparam logic ModeClear = 1'b0;
  localparam logic ModeAdd   = 1'b1;

  typedef struct packed {
    logic            mode;
    logic [DirW-1:0] direction;
  } in_item_t;

  typedef struct packed {
    logic            accepted;
    logic            average_valid;
    logic [DirW-1:0] average_position;
    logic [DegW-1:0] average_degrees;
  } out_item_t;

  typedef struct packed {
    logic            accepted;
    logic [CntW-1:0] count;
    logic [SumW-1:0] sum;
  } job_t;

endpackage

// File: hw/rtl/wdua_front.sv
// ----------------------------------------------------------------------------
// wdua_front
// Accepts items, unwraps samples and keeps count, sum and last value.
// ----------------------------------------------------------------------------
module wdua_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  output logic              full,
  input  wdua_pkg::in_item_t in_item_i,
  input  logic              queue_full_i,
  output logic              job_we_o,
  output wdua_pkg::job_t    job_o
);

  logic [wdua_pkg::CntW-1:0]  count_q, count_d;
  logic [wdua_pkg::SumW-1:0]  sum_q, sum_d;
  logic [wdua_pkg::LastW-1:0] last_q, last_d;
  logic [wdua_pkg::DirW-1:0]  diff;
  logic [wdua_pkg::LastW-1:0] last_step;
  logic                       take;
  logic                       acc;

  assign full = queue_full_i;
  assign take = push & ~queue_full_i;
  assign diff = in_item_i.direction - last_q[wdua_pkg::DirW-1:0];
  assign last_step = last_q + {{(wdua_pkg::LastW - wdua_pkg::DirW){diff[wdua_pkg::DirW-1]}},
                               diff};

  always_comb begin
    count_d = count_q;
    sum_d   = sum_q;
    last_d  = last_q;
    acc     = 1'b0;
    if (in_item_i.mode == wdua_pkg::ModeClear) begin
      count_d = '0;
      sum_d   = '0;
      last_d  = '0;
      acc     = 1'b1;
    end else if (count_q >= wdua_pkg::CntW'(wdua_pkg::MaxSamples)) begin
      acc = 1'b0;
    end else if (count_q == '0) begin
      count_d = wdua_pkg::CntW'(1);
      sum_d   = wdua_pkg::SumW'(in_item_i.direction);
      last_d  = wdua_pkg::LastW'(in_item_i.direction);
      acc     = 1'b1;
    end else if (diff != wdua_pkg::HalfTurn) begin
      last_d  = last_step;
      sum_d   = sum_q + {{(wdua_pkg::SumW - wdua_pkg::LastW){last_step[wdua_pkg::LastW-1]}},
                         last_step};
      count_d = count_q + wdua_pkg::CntW'(1);
      acc     = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      sum_q   <= '0;
      last_q  <= '0;
    end else if (take) begin
      count_q <= count_d;
      sum_q   <= sum_d;
      last_q  <= last_d;
    end
  end

  assign job_we_o       = take;
  assign job_o.accepted = acc;
  assign job_o.count    = count_d;
  assign job_o.sum      = sum_d;

endmodule

// File: hw/rtl/wdua_queue.sv
// ----------------------------------------------------------------------------
// wdua_queue
// Short queue of classified items between the front and the back.
// ----------------------------------------------------------------------------
module wdua_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           we_i,
  input  wdua_pkg::job_t wdata_i,
  output logic           full_o,
  input  logic           re_i,
  output logic           empty_o,
  output wdua_pkg::job_t rdata_o
);

  wdua_pkg::job_t                  mem_q [wdua_pkg::QueueDepth];
  logic [wdua_pkg::QueuePtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [wdua_pkg::QueueCntW-1:0]  cnt_q;
  logic                            do_wr, do_rd;

  assign full_o  = (cnt_q == wdua_pkg::QueueCntW'(wdua_pkg::QueueDepth));
  assign empty_o = (cnt_q == '0);
  assign do_wr   = we_i & ~full_o;
  assign do_rd   = re_i & ~empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= (wr_ptr_q == wdua_pkg::QueuePtrW'(wdua_pkg::QueueDepth - 1)) ?
                    '0 : wr_ptr_q + wdua_pkg::QueuePtrW'(1);
      end
      if (do_rd) begin
        rd_ptr_q <= (rd_ptr_q == wdua_pkg::QueuePtrW'(wdua_pkg::QueueDepth - 1)) ?
                    '0 : rd_ptr_q + wdua_pkg::QueuePtrW'(1);
      end
      if (do_wr && !do_rd) begin
        cnt_q <= cnt_q + wdua_pkg::QueueCntW'(1);
      end else if (do_rd && !do_wr) begin
        cnt_q <= cnt_q - wdua_pkg::QueueCntW'(1);
      end
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= wdua_pkg::QueueCntW'(wdua_pkg::QueueDepth))
    else $error("queue count beyond depth");

  a_cnt_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_wr && !do_rd) |=> (cnt_q == $past(cnt_q) + wdua_pkg::QueueCntW'(1)))
    else $error("queue count did not grow on write");

  a_cnt_down: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_rd && !do_wr) |=> (cnt_q == $past(cnt_q) - wdua_pkg::QueueCntW'(1)))
    else $error("queue count did not shrink on read");

endmodule

// File: hw/rtl/wdua_back.sv
// ----------------------------------------------------------------------------
// wdua_back
// Divides sum by count bit-serially and forms the result item.
// ----------------------------------------------------------------------------
module wdua_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [wdua_pkg::DirW-1:0] cfg_data_i,
  input  logic                      queue_empty_i,
  input  wdua_pkg::job_t            job_i,
  output logic                      queue_re_o,
  output logic                      empty,
  input  logic                      pop,
  output wdua_pkg::out_item_t       out_item_o
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StDiv  = 2'd1;
  localparam logic [1:0] StOut  = 2'd2;

  logic [1:0]                  state_q, state_d;
  logic [wdua_pkg::DirW-1:0]   north_q;
  logic [wdua_pkg::IterW-1:0]  iter_q;
  logic [wdua_pkg::SumW-1:0]   quo_q;
  logic [wdua_pkg::CntW-1:0]   rem_q;
  logic [wdua_pkg::CntW-1:0]   div_q;
  logic                        neg_q;
  logic                        acc_q;
  logic                        avg_valid_q;
  logic                        out_valid_q;
  wdua_pkg::out_item_t         out_q;

  logic [wdua_pkg::CntW:0]     rem_shift;
  logic                        ge;
  logic [wdua_pkg::CntW:0]     rem_sub;
  logic [wdua_pkg::DirW-1:0]   pos;
  logic [wdua_pkg::DirW-1:0]   rot;
  logic [wdua_pkg::ProdW-1:0]  prod;
  logic                        load_out;
  logic                        take;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      north_q <= '0;
    end else if (cfg_valid_i) begin
      north_q <= cfg_data_i;
    end
  end

  assign rem_shift = {rem_q, quo_q[wdua_pkg::SumW-1]};
  assign ge        = (rem_shift >= {1'b0, div_q});
  assign rem_sub   = rem_shift - {1'b0, div_q};

  assign pos  = avg_valid_q ? (neg_q ? -quo_q[wdua_pkg::DirW-1:0] : quo_q[wdua_pkg::DirW-1:0])
                            : '0;
  assign rot  = north_q - pos;
  assign prod = {{wdua_pkg::DegW{1'b0}}, rot} * wdua_pkg::ProdW'(wdua_pkg::DegPerTurn);

  assign take       = (state_q == StIdle) && !queue_empty_i;
  assign queue_re_o = take;
  assign load_out   = (state_q == StOut) && (!out_valid_q || pop);

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (take) begin
          state_d = (job_i.count == '0) ? StOut : StDiv;
        end
      end
      StDiv: begin
        if (iter_q == wdua_pkg::IterW'(wdua_pkg::SumW - 1)) begin
          state_d = StOut;
        end
      end
      StOut: begin
        if (load_out) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (pop) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      acc_q       <= job_i.accepted;
      avg_valid_q <= (job_i.count != '0);
      div_q       <= job_i.count;
      neg_q       <= job_i.sum[wdua_pkg::SumW-1];
      quo_q       <= job_i.sum[wdua_pkg::SumW-1] ? -job_i.sum : job_i.sum;
      rem_q       <= '0;
      iter_q      <= '0;
    end else if (state_q == StDiv) begin
      quo_q  <= {quo_q[wdua_pkg::SumW-2:0], ge};
      rem_q  <= ge ? rem_sub[wdua_pkg::CntW-1:0] : rem_shift[wdua_pkg::CntW-1:0];
      iter_q <= iter_q + wdua_pkg::IterW'(1);
    end
    if (load_out) begin
      out_q.accepted         <= acc_q;
      out_q.average_valid    <= avg_valid_q;
      out_q.average_position <= pos;
      out_q.average_degrees  <= avg_valid_q ?
                                prod[wdua_pkg::ProdW-1:wdua_pkg::DirW] : '0;
    end
  end

  assign empty      = ~out_valid_q;
  assign out_item_o = out_q;

  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDiv) |-> (div_q != '0))
    else $error("division started with a zero count");

  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDiv) |-> (rem_q < div_q))
    else $error("partial remainder not below divisor");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !pop) |-> !load_out)
    else $error("result overwritten before it was taken");

  a_take_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |=> (state_q == StDiv || state_q == StOut))
    else $error("queued item taken without starting work");

endmodule

// File: hw/rtl/wind_direction_unwrap_averager_unit.sv
// ----------------------------------------------------------------------------
// wind_direction_unwrap_averager_unit
// Averages wind vane directions with unwrapping across the 0/255 seam.
// ----------------------------------------------------------------------------
// Items are written like a queue: in_item_i is taken on a clock edge with
// push high and full low. Each item is a clear or a direction sample.
// Results are read like a queue: while empty is low, out_item_o carries the
// oldest result, and pop high on a clock edge takes it. Every item gives
// exactly one result, in order.
// The front updates count, sum and last unwrapped value in the cycle the
// item is taken and passes a snapshot through a two-entry queue. The back
// divides the sum by the count with a restoring divider, one quotient bit
// per cycle over the 24 divider steps; a clear skips the divider. The back
// takes a new item from the queue only after the result of the last one
// has been loaded into the output register.
// The north offset is written through cfg_valid_i and cfg_data_i, always
// ready, and must be written only while no item is in flight.
// Reset clears the state, the queue and the offset. When the receiver
// stalls, the result is held; the queue fills and full rises.
// ----------------------------------------------------------------------------
module wind_direction_unwrap_averager_unit (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      push,
  output logic                      full,
  input  wdua_pkg::in_item_t        in_item_i,
  output logic                      empty,
  input  logic                      pop,
  output wdua_pkg::out_item_t       out_item_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [wdua_pkg::DirW-1:0] cfg_data_i
);

  wdua_pkg::job_t wjob;
  wdua_pkg::job_t rjob;
  logic           job_we;
  logic           queue_full;
  logic           queue_empty;
  logic           queue_re;

  wdua_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .in_item_i    (in_item_i),
    .queue_full_i (queue_full),
    .job_we_o     (job_we),
    .job_o        (wjob)
  );

  wdua_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (job_we),
    .wdata_i (wjob),
    .full_o  (queue_full),
    .re_i    (queue_re),
    .empty_o (queue_empty),
    .rdata_o (rjob)
  );

  wdua_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .queue_empty_i (queue_empty),
    .job_i         (rjob),
    .queue_re_o    (queue_re),
    .empty         (empty),
    .pop           (pop),
    .out_item_o    (out_item_o)
  );

endmodule
